/* src/pelc_pkg.sv */
// pelc_pkg: shared types and codes for the PIN entry lock controller.
// Depends on nothing; imported by pin_entry_lock_controller.
`timescale 1ns / 1ps
package pelc_pkg;

	// Number of digits in a full PIN and in the entry buffer
	localparam int PIN_DIGITS = 8;
	// Width of the entry buffer fill count (must hold PIN_DIGITS itself)
	localparam int CNT_W      = $clog2(PIN_DIGITS + 1);
	// Width of a buffer slot index
	localparam int IDX_W      = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

	// Field widths of the stream payloads
	localparam int ACTION_W   = 2;
	localparam int DIGIT_W    = 4;
	localparam int STATUS_W   = 3;
	localparam int MODE_W     = 2;
	localparam int DCOUNT_W   = 4;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CNT_W-1:0]   count_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DIGIT  = 2'd0,
		ACT_ENTER  = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_CHANGE = 2'd3
	} action_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_VERIFY  = 2'd0,
		MODE_FIRST   = 2'd1,
		MODE_CONFIRM = 2'd2,
		MODE_OPEN    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED  = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_LENGTH   = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_STORED   = 3'd4,
		ST_UNLOCKED = 3'd5
	} status_t;

endpackage

/* src/pin_entry_lock_controller.sv */
// pin_entry_lock_controller: keypad PIN lock, key events in, one status transfer out.
// Depends on pelc_pkg.
`timescale 1ns / 1ps
// Each key event (digit, enter, delete, change PIN) taken on the slave stream
// produces exactly one result transfer on the master stream: a status code, the
// lock mode after the event and the number of digits held in the entry buffer.
// An event is captured in an input register, then decoded against the lock
// state by short logic (append/drop a digit, an 8-way parallel digit compare,
// a PIN copy) whose outcome lands in the output register. One event per clock
// is sustained while the master side does not hold back; each event passes
// through the input register and then the output register before its result
// transfer. The input register is refilled in the same cycle
// its event moves on, so backpressure on the master side stalls the slave side
// only when both registers are full. After reset the lock is in set-first mode
// with no stored PIN and an empty buffer; no clearing pass is needed.
module pin_entry_lock_controller
	import pelc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// key event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] status, [4:3] mode_now, [8:5] digit_count, [15:9] zero
);

	// ---------------------------------------------------------------- stage 1
	logic    valid_s1;
	action_t action_s1;
	digit_t  digit_s1;
	logic    advance;

	// stage 1 moves on when the output register is empty or being drained
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= action_t'(s_tuser);
			digit_s1  <= s_tdata[DIGIT_W-1:0];
		end
	end

	// ------------------------------------------------------------ lock state
	mode_t  mode_q;
	count_t cnt_q;
	logic   pin_valid_q;
	digit_t entry_q  [PIN_DIGITS];  // no reset: read only once written
	digit_t stored_q [PIN_DIGITS];  // no reset: read only with pin_valid_q

	logic    locked;
	logic    full;
	logic    match;
	mode_t   mode_d;
	count_t  cnt_d;
	logic    pin_valid_d;
	status_t status_d;
	logic    wr_digit;     // append digit_s1 at slot cnt_q
	logic    store_pin;    // copy the buffer into the stored PIN

	assign locked = (mode_q != MODE_OPEN);
	assign full   = (cnt_q == CNT_W'(PIN_DIGITS));

	// digit-wise compare; the buffer is only compared when full
	always_comb begin
		match = pin_valid_q;
		for (int k = 0; k < PIN_DIGITS; k++) begin
			if (entry_q[k] != stored_q[k]) match = 1'b0;
		end
	end

	always_comb begin
		mode_d      = mode_q;
		cnt_d       = cnt_q;
		pin_valid_d = pin_valid_q;
		status_d    = ST_IGNORED;
		wr_digit    = 1'b0;
		store_pin   = 1'b0;
		unique case (action_s1)
			ACT_DIGIT: begin
				if (locked && digit_s1 <= DIGIT_MAX && !full) begin
					wr_digit = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					status_d = ST_ACCEPTED;
				end
			end
			ACT_ENTER: begin
				if (locked) begin
					cnt_d = '0;  // enter always empties the buffer
					if (!full) begin
						status_d = ST_LENGTH;
					end else if (mode_q == MODE_FIRST) begin
						store_pin   = 1'b1;
						pin_valid_d = 1'b1;
						mode_d      = MODE_CONFIRM;
						status_d    = ST_STORED;
					end else if (match) begin
						mode_d   = MODE_OPEN;
						status_d = ST_UNLOCKED;
					end else begin
						if (mode_q == MODE_CONFIRM) mode_d = MODE_FIRST;
						status_d = ST_MISMATCH;
					end
				end
			end
			ACT_DELETE: begin
				if (locked && cnt_q != '0) begin
					cnt_d    = cnt_q - 1'b1;
					status_d = ST_ACCEPTED;
				end
			end
			ACT_CHANGE: begin
				if (!locked) begin
					cnt_d    = '0;
					mode_d   = MODE_FIRST;
					status_d = ST_ACCEPTED;
				end
			end
			default: begin
				status_d = ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FIRST;
			cnt_q       <= '0;
			pin_valid_q <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_d;
			cnt_q       <= cnt_d;
			pin_valid_q <= pin_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_digit) begin
			entry_q[cnt_q[IDX_W-1:0]] <= digit_s1;
		end
		if (advance && store_pin) begin
			stored_q <= entry_q;
		end
	end

	// -------------------------------------------------------- output register
	status_t status_q;
	mode_t   mode_out_q;
	count_t  cnt_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= status_d;
			mode_out_q <= mode_d;
			cnt_out_q  <= cnt_d;
		end
	end

	assign m_tdata = {7'd0, DCOUNT_W'(cnt_out_q), mode_out_q, status_q};

endmodule
